>>> rtl/tksp_pkg.sv
// Shared types, request and status codes for the two-key sorted priority list.
package tksp_pkg;

	// Default table depth
	localparam int unsigned CAPACITY_DEF = 16;

	// Request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_BAD_POS   = 2'd3;

	// Rank stored for an insert that carries rank zero
	localparam logic [1:0] RANK_TOP = 2'd1;

	// One table entry
	typedef struct packed {
		logic [1:0]  rank;
		logic [31:0] salary;
		logic [15:0] tag;
	} entry_t;

endpackage

>>> rtl/tksp_ram.sv
// Entry memory: one write port, one read port with registered read data.
module tksp_ram #(
	parameter int unsigned DEPTH = tksp_pkg::CAPACITY_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output tksp_pkg::entry_t     rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  tksp_pkg::entry_t     wr_data
);

	tksp_pkg::entry_t mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry; the read data is registered and appears in the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/two_key_sorted_priority_list_top.sv
// Top level of the two-key sorted priority list: request sequencer around the entry memory.
//
//  channel | valid     | stall     | beat fields
//  --------+-----------+-----------+-------------------------------------------------
//  request | in_valid  | in_stall  | req_type, class_rank, salary, tag, position
//  result  | out_valid | out_stall | status, count, out_rank, out_salary, out_tag
//
// Insert and remove walk the list once through the single memory read port,
// moving entries by one place as they pass.
// A read at a valid position passes through the read state to the result state;
// a read at a bad position, a full-table insert or an unused request goes straight to the result state.
// Reset empties the list at once (count to zero); memory contents need no clearing.
// A new request beat is taken while an earlier result beat still waits under out_stall;
// the sequencer then holds in its result state until the output register frees.
module two_key_sorted_priority_list_top #(
	parameter int unsigned CAPACITY = tksp_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [1:0]  class_rank,
	input  logic [31:0] salary,
	input  logic [15:0] tag,
	input  logic [3:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [4:0]  count,
	output logic [1:0]  out_rank,
	output logic [31:0] out_salary,
	output logic [15:0] out_tag
);

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned PW   = $clog2(CAPACITY + 2);
	localparam int unsigned CMPW = (CW > 4) ? CW : 4;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_RESP = 3'd3;

	logic [2:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [1:0]       op_q;
	tksp_pkg::entry_t key_q;
	tksp_pkg::entry_t carry_q;
	logic [PW-1:0]    ptr_q;
	logic             v_s1;
	logic [PW-1:0]    idx_s1;
	logic             done_q;
	logic [1:0]       res_status_q;
	tksp_pkg::entry_t res_entry_q;
	logic             out_valid_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	tksp_pkg::entry_t rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	tksp_pkg::entry_t wr_data;

	logic             in_acc;
	logic             out_free;
	logic             pos_ok;
	logic             is_full;
	logic [PW-1:0]    count_p;
	logic             at_end;
	logic             issue;
	logic             skip;
	logic             take;
	logic             hit;
	logic [PW-1:0]    idx_m1;
	logic [1:0]       new_rank;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign pos_ok   = CMPW'(position) < CMPW'(count_q);
	assign is_full  = (count_q == CW'(CAPACITY));
	assign count_p  = PW'(count_q);
	assign at_end   = (idx_s1 == count_p);
	assign issue    = (state_q == S_SCAN) && (ptr_q <= count_p);
	assign idx_m1   = idx_s1 - PW'(1);
	assign new_rank = (class_rank == 2'd0) ? tksp_pkg::RANK_TOP : class_rank;

	// Insert walk: pass entries of better rank, or same rank and higher salary
	assign skip = (rd_data.rank < key_q.rank) ||
		((rd_data.rank == key_q.rank) && (key_q.salary < rd_data.salary));
	assign take = !done_q && (at_end || !skip);
	// Remove walk: first entry whose salary equals the key
	assign hit  = !done_q && !at_end && (rd_data.salary == key_q.salary);

	// Drive the read port
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (in_acc && (req_type == tksp_pkg::REQ_READ) && pos_ok) begin
			rd_en   = 1'b1;
			rd_addr = AW'(position);
		end else if (issue && (ptr_q < count_p)) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q[AW-1:0];
		end
	end

	// Drive the write port: ripple entries one place during a walk
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1[AW-1:0];
		wr_data = key_q;
		if ((state_q == S_SCAN) && v_s1) begin
			if (op_q == tksp_pkg::REQ_INSERT) begin
				if (take) begin
					wr_en = 1'b1;
				end else if (done_q) begin
					wr_en   = 1'b1;
					wr_data = carry_q;
				end
			end else if (done_q && !at_end) begin
				wr_en   = 1'b1;
				wr_addr = idx_m1[AW-1:0];
				wr_data = rd_data;
			end
		end
	end

	tksp_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise, hold or drop the result beat
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					ptr_q  <= '0;
					v_s1   <= 1'b0;
					done_q <= 1'b0;
					if (in_acc) begin
						case (req_type)
							tksp_pkg::REQ_INSERT: state_q <= is_full ? S_RESP : S_SCAN;
							tksp_pkg::REQ_REMOVE: state_q <= S_SCAN;
							tksp_pkg::REQ_READ:   state_q <= pos_ok ? S_READ : S_RESP;
							default:              state_q <= S_RESP;
						endcase
					end
				end
				S_SCAN: begin
					// Advance the read pointer one entry a cycle
					v_s1 <= issue;
					if (issue) begin
						ptr_q  <= ptr_q + PW'(1);
						idx_s1 <= ptr_q;
					end
					if (v_s1) begin
						if ((op_q == tksp_pkg::REQ_INSERT) ? take : hit) begin
							done_q <= 1'b1;
						end
						if (at_end) begin
							state_q <= S_RESP;
							if (op_q == tksp_pkg::REQ_INSERT) begin
								count_q <= count_q + CW'(1);
							end else if (done_q) begin
								count_q <= count_q - CW'(1);
							end
						end
					end
				end
				S_READ: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload, carried entry and result staging
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q         <= req_type;
			key_q.rank   <= new_rank;
			key_q.salary <= salary;
			key_q.tag    <= tag;
			res_entry_q  <= '0;
			case (req_type)
				tksp_pkg::REQ_INSERT: begin
					res_status_q <= is_full ? tksp_pkg::ST_FULL : tksp_pkg::ST_OK;
				end
				tksp_pkg::REQ_READ: begin
					res_status_q <= pos_ok ? tksp_pkg::ST_OK : tksp_pkg::ST_BAD_POS;
				end
				default: res_status_q <= tksp_pkg::ST_OK;
			endcase
		end
		if ((state_q == S_SCAN) && v_s1) begin
			if (op_q == tksp_pkg::REQ_INSERT) begin
				if (take || done_q) begin
					carry_q <= rd_data;
				end
			end else begin
				if (hit) begin
					res_entry_q <= rd_data;
				end
				if (at_end && !done_q) begin
					res_status_q <= tksp_pkg::ST_NOT_FOUND;
				end
			end
		end
		if (state_q == S_READ) begin
			res_entry_q <= rd_data;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && out_free) begin
			status     <= res_status_q;
			count      <= 5'(count_q);
			out_rank   <= res_entry_q.rank;
			out_salary <= res_entry_q.salary;
			out_tag    <= res_entry_q.tag;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/tksp_checker.sv
// Port-level checks for the two-key sorted priority list, bound to the top level.
module tksp_checker #(
	parameter int unsigned CAPACITY = tksp_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [4:0]  count,
	input logic [1:0]  out_rank,
	input logic [31:0] out_salary,
	input logic [15:0] out_tag
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(count) &&
			$stable(out_rank) && $stable(out_salary) && $stable(out_tag))
		else $error("stalled result beat changed");

	// One request at a time: busy right after a request beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still in work");

	// Full only at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tksp_pkg::ST_FULL) |-> count == 5'(CAPACITY))
		else $error("full status below capacity");

	// Failed requests carry no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != tksp_pkg::ST_OK) |->
			(out_rank == 2'd0) && (out_salary == 32'd0) && (out_tag == 16'd0))
		else $error("failed request returned entry data");

endmodule

bind two_key_sorted_priority_list_top tksp_checker #(
	.CAPACITY(CAPACITY)
) u_tksp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.count     (count),
	.out_rank  (out_rank),
	.out_salary(out_salary),
	.out_tag   (out_tag)
);

>>> bench/tb_top.sv
// Self-checking testbench for the two-key sorted priority list: shadow table, random traffic.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tksp_pkg::*;

	localparam int unsigned TABLE_DEPTH = CAPACITY_DEF;
	localparam int unsigned CLK_PERIOD  = 10;
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int unsigned SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;

	// One request beat and one result beat
	typedef struct {
		logic [1:0]  req_type;
		logic [1:0]  rank;
		logic [31:0] salary;
		logic [15:0] tag;
		logic [3:0]  position;
	} list_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [4:0]  count;
		logic [1:0]  rank;
		logic [31:0] salary;
		logic [15:0] tag;
	} list_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_NONE;
	logic [1:0]  class_rank = 2'd0;
	logic [31:0] salary = 32'd0;
	logic [15:0] tag = 16'd0;
	logic [3:0]  position = 4'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [4:0]  count;
	logic [1:0]  out_rank;
	logic [31:0] out_salary;
	logic [15:0] out_tag;

	// Shadow copy of the table, head first, and results still owed by the block
	entry_t      shadow_list[$];
	list_rsp_t   awaited_results[$];

	int unsigned send_gap_mode = 0;
	int unsigned result_stall_mode = 0;
	int unsigned error_count = 0;
	int unsigned sent_count = 0;
	int unsigned checked_count = 0;
	int unsigned cycle_count = 0;
	int unsigned status_tally[4] = '{0, 0, 0, 0};

	two_key_sorted_priority_list_top #(
		.CAPACITY(TABLE_DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.class_rank(class_rank),
		.salary    (salary),
		.tag       (tag),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.count     (count),
		.out_rank  (out_rank),
		.out_salary(out_salary),
		.out_tag   (out_tag)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still owed",
				cycle_count, awaited_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned idle_length(int unsigned mode);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (mode == 0)
			return 0;
		if (mode == 1) begin
			if (roll < 70) return 0;
			if (roll < 95) return $urandom_range(1, 3);
			return $urandom_range(8, 30);
		end
		if (roll < 30) return 0;
		if (roll < 80) return $urandom_range(1, 4);
		return $urandom_range(8, 30);
	endfunction

	// Advance the shadow table by one request and return the result it owes
	function automatic list_rsp_t apply_request(list_req_t r);
		list_rsp_t res;
		entry_t    ent;
		logic [1:0] rk;
		int        p;
		int        hit;
		res.status = ST_OK;
		res.rank   = 2'd0;
		res.salary = 32'd0;
		res.tag    = 16'd0;
		case (r.req_type)
			REQ_INSERT: begin
				rk = (r.rank == 2'd0) ? RANK_TOP : r.rank;
				if (shadow_list.size() >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					// skip better ranks, then same rank with higher salary
					p = 0;
					while (p < shadow_list.size() && shadow_list[p].rank < rk)
						p++;
					while (p < shadow_list.size() && shadow_list[p].rank == rk &&
							r.salary < shadow_list[p].salary)
						p++;
					ent.rank   = rk;
					ent.salary = r.salary;
					ent.tag    = r.tag;
					shadow_list.insert(p, ent);
				end
			end
			REQ_REMOVE: begin
				hit = -1;
				for (p = 0; p < shadow_list.size(); p++) begin
					if (shadow_list[p].salary == r.salary) begin
						hit = p;
						break;
					end
				end
				if (hit < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.rank   = shadow_list[hit].rank;
					res.salary = shadow_list[hit].salary;
					res.tag    = shadow_list[hit].tag;
					shadow_list.delete(hit);
				end
			end
			REQ_READ: begin
				if (r.position >= shadow_list.size()) begin
					res.status = ST_BAD_POS;
				end else begin
					res.rank   = shadow_list[r.position].rank;
					res.salary = shadow_list[r.position].salary;
					res.tag    = shadow_list[r.position].tag;
				end
			end
			default: begin
				// unused request: no change
			end
		endcase
		res.count = 5'(shadow_list.size());
		return res;
	endfunction

	function automatic list_req_t make_req(logic [1:0] kind, logic [1:0] rk,
			logic [31:0] sal, logic [15:0] tg, logic [3:0] pos);
		list_req_t r;
		r.req_type = kind;
		r.rank     = rk;
		r.salary   = sal;
		r.tag      = tg;
		r.position = pos;
		return r;
	endfunction

	// Random request, mostly well formed against the current table contents
	function automatic list_req_t make_request(int unsigned insert_pct);
		list_req_t   r;
		int unsigned roll;
		int unsigned n;
		n = shadow_list.size();
		roll = $urandom_range(0, 99);
		r.tag = 16'($urandom_range(0, 65535));
		r.rank = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
		r.position = 4'($urandom_range(0, 15));
		// small salary pool makes ties common
		case ($urandom_range(0, 9))
			0: r.salary = 32'd0;
			1: r.salary = 32'hFFFF_FFFF;
			2, 3, 4, 5: r.salary = 32'($urandom_range(0, 7) * 1000);
			default: r.salary = $urandom();
		endcase
		if (roll < insert_pct) begin
			r.req_type = REQ_INSERT;
		end else if (roll < insert_pct + (100 - insert_pct) * 55 / 100) begin
			r.req_type = REQ_REMOVE;
			if (n != 0 && $urandom_range(0, 3) != 0)
				r.salary = shadow_list[$urandom_range(0, n - 1)].salary;
		end else if (roll < 97) begin
			r.req_type = REQ_READ;
			if (n != 0 && $urandom_range(0, 4) != 0)
				r.position = 4'($urandom_range(0, n - 1));
		end else begin
			r.req_type = REQ_NONE;
		end
		return r;
	endfunction

	// Send one request beat; returns at the edge that took it
	task automatic push_request(list_req_t r);
		int unsigned gap;
		gap = idle_length(send_gap_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= r.req_type;
		class_rank <= r.rank;
		salary     <= r.salary;
		tag        <= r.tag;
		position   <= r.position;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		awaited_results.push_back(apply_request(r));
		sent_count++;
	endtask

	// Hold off the sender until every owed result has come back
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch on result %0d: %s", $time, checked_count, msg);
		error_count++;
	endtask

	// Result stall: random bursts according to the current mode
	initial begin : result_stall_gen
		int unsigned len;
		forever begin
			@(posedge clk);
			len = idle_length(result_stall_mode);
			if (len == 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat (len - 1) @(posedge clk);
			end
		end
	end

	// Compare each accepted result beat with the oldest owed result
	always @(posedge clk) begin
		list_rsp_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result beat with nothing owed");
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (count !== want.count)
					report_mismatch($sformatf("count %0d, want %0d", count, want.count));
				if (out_rank !== want.rank)
					report_mismatch($sformatf("rank %0d, want %0d", out_rank, want.rank));
				if (out_salary !== want.salary)
					report_mismatch($sformatf("salary %h, want %h", out_salary, want.salary));
				if (out_tag !== want.tag)
					report_mismatch($sformatf("tag %h, want %h", out_tag, want.tag));
				status_tally[want.status]++;
			end
			checked_count++;
		end
	end

	// Requests against an empty table
	task automatic test_empty_list();
		send_gap_mode = 0;
		result_stall_mode = 0;
		push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'd0));
		push_request(make_req(REQ_READ, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 4'd15));
		push_request(make_req(REQ_REMOVE, 2'd0, 32'd0, 16'd0, 4'd0));
		push_request(make_req(REQ_NONE, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 4'd15));
		wait_results_done();
	endtask

	// Rank order, salary order, ties, rank zero, first-match remove
	task automatic test_sort_order();
		send_gap_mode = 1;
		result_stall_mode = 1;
		push_request(make_req(REQ_INSERT, 2'd3, 32'd500, 16'h0001, 4'd0));
		push_request(make_req(REQ_INSERT, 2'd1, 32'd0, 16'hFFFF, 4'd15));
		push_request(make_req(REQ_INSERT, 2'd2, 32'hFFFF_FFFF, 16'h0000, 4'd0));
		push_request(make_req(REQ_INSERT, 2'd0, 32'd0, 16'h0002, 4'd0));
		push_request(make_req(REQ_INSERT, 2'd2, 32'd7, 16'h0003, 4'd0));
		push_request(make_req(REQ_INSERT, 2'd2, 32'hFFFF_FFFF, 16'h0004, 4'd0));
		push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'd0));
		push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'd1));
		push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'd2));
		push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'd5));
		push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'd6));
		push_request(make_req(REQ_REMOVE, 2'd0, 32'hFFFF_FFFF, 16'd0, 4'd0));
		push_request(make_req(REQ_REMOVE, 2'd0, 32'd12345, 16'd0, 4'd0));
		push_request(make_req(REQ_NONE, 2'd1, 32'hA5A5_5A5A, 16'h5A5A, 4'd10));
		push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'd2));
		wait_results_done();
	endtask

	// Fill to capacity, hit the full case, read the tail, then empty it again
	task automatic test_full_table();
		int unsigned round;
		send_gap_mode = 1;
		result_stall_mode = 1;
		for (round = 0; round < 3; round++) begin
			while (shadow_list.size() < TABLE_DEPTH)
				push_request(make_request(100));
			push_request(make_request(100));
			push_request(make_req(REQ_READ, 2'd0, 32'd0, 16'd0, 4'(TABLE_DEPTH - 1)));
			while (shadow_list.size() > 0)
				push_request(make_req(REQ_REMOVE, 2'd0,
					shadow_list[$urandom_range(0, shadow_list.size() - 1)].salary,
					16'd0, 4'd0));
			push_request(make_req(REQ_REMOVE, 2'd0, $urandom(), 16'd0, 4'd0));
			send_gap_mode = 2;
			result_stall_mode = 2;
		end
		wait_results_done();
	endtask

	// Long random phases with different insert bias and idling
	task automatic test_random_traffic();
		int unsigned phase;
		int unsigned k;
		int unsigned insert_pct[4] = '{70, 30, 50, 55};
		int unsigned gap_mode[4]   = '{0, 1, 2, 1};
		int unsigned stall_mode[4] = '{0, 1, 2, 2};
		for (phase = 0; phase < 4; phase++) begin
			send_gap_mode = gap_mode[phase];
			result_stall_mode = stall_mode[phase];
			for (k = 0; k < 450; k++)
				push_request(make_request(insert_pct[phase]));
			wait_results_done();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_sort_order();
		test_full_table();
		test_random_traffic();

		// let any stray beat show up before judging
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d results in %0d cycles",
			sent_count, checked_count, cycle_count);
		$display("Status seen: ok %0d, full %0d, not found %0d, bad position %0d",
			status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_NOT_FOUND],
			status_tally[ST_BAD_POS]);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
